@@ rtl/otaif_pkg.sv @@
// ----------------------------------------------------------------------------
// otaif_pkg
// Shared types and constants for the OTA image fetch receiver.
// ----------------------------------------------------------------------------
package otaif_pkg;

  localparam int unsigned CHUNK_BYTES = 64;
  localparam int unsigned BANK_SPAN   = 12288;
  localparam int unsigned RETRY_LIMIT = 5;

  localparam int unsigned OFF_W   = 16;
  localparam int unsigned CLEN_W  = 7;
  localparam int unsigned RETRY_W = 3;
  localparam int unsigned IN_W    = 128;
  localparam int unsigned OUT_W   = 112;

  // stream tuser codes
  typedef enum logic [1:0] {
    CMD_ADVERT   = 2'd0,
    CMD_RESPONSE = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_BANK0 = 3'b010,
    MODE_BANK1 = 3'b100
  } mode_t;

  // register indexes on the APB port (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_ARCH         = 2'd0,
    REG_BASE         = 2'd1,
    REG_VERSION_LOW  = 2'd2,
    REG_VERSION_HIGH = 2'd3
  } reg_idx_t;

  // input word, last field in the lowest bits
  typedef struct packed {
    logic [31:0] sender_mac_low;
    logic [31:0] sender_mac_high;
    logic [15:0] pkt_length;
    logic [15:0] pkt_offset;
    logic [7:0]  pkt_version_high;
    logic [7:0]  pkt_version_low;
    logic [7:0]  pkt_base;
    logic [7:0]  pkt_arch;
  } pkt_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic [2:0]  pad;
    logic        target_bank;
    logic [6:0]  chunk_length;
    logic        transfer_done;
    logic        accepted;
    logic        stop_timer;
    logic        start_timer;
    logic [31:0] dest_mac_low;
    logic [31:0] dest_mac_high;
    logic [15:0] req_offset;
    logic [7:0]  req_version_high;
    logic [7:0]  req_version_low;
    logic        send_request;
  } result_t;

endpackage

@@ rtl/ota_image_fetch_protocol.sv @@
// ----------------------------------------------------------------------------
// ota_image_fetch_protocol
// Receive side of a chunked over-the-air image fetch.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries one packet or timer tick per word; tuser holds
//   the kind (advertisement, chunk response, retry tick). Master stream (m_*)
//   returns exactly one result word per input word: request/timer flags, the
//   fetch version, next offset, peer MAC, chunk length and target bank.
//   The APB port writes and reads the arch, code base and running version.
//   Throughput: one word per cycle. All state is updated at the accept edge
//   by one pass of compares and a 17-bit add; the result is registered into
//   the output register, or into the skid register while a result waits.
//   A one-word skid register sits behind the output register, so a word is
//   still taken while a result waits; once both hold data s_tready drops
//   until the receiver takes one. Results are never dropped or reordered.
//   Reset sets the fetch mode idle, clears the other fetch state and registers
//   to zero and empties both output stages; the block is idle and ready on the first cycle after.
// ----------------------------------------------------------------------------
module ota_image_fetch_protocol
  import otaif_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  // arch, base, version_low, version_high, offset, length,
  // mac_high, mac_low
  input  logic [IN_W-1:0]   s_tdata,
  input  logic [1:0]        s_tuser,  // cmd
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // send_request, req_version_low, req_version_high, req_offset,
  // dest_mac_high, dest_mac_low, start_timer, stop_timer, accepted,
  // transfer_done, chunk_length, target_bank, zero pad
  output logic [OUT_W-1:0]  m_tdata
);

  logic [7:0] own_arch, running_base, running_version_low, running_version_high;

  mode_t              fetch_mode, fetch_mode_next;
  logic [RETRY_W-1:0] retries_left, retries_left_next;
  logic [OFF_W-1:0]   next_offset, next_offset_next;
  logic [7:0]         fetch_version_low, fetch_version_low_next;
  logic [7:0]         fetch_version_high, fetch_version_high_next;
  logic [63:0]        peer_mac, peer_mac_next;
  logic               bank_choice, bank_choice_next;

  result_t res, out_q, skid_q;
  logic    skid_valid;
  logic    in_fire, out_fire, cfg_wr;
  pkt_t    pkt;
  cmd_t    cmd;

  logic             match, newer_run, newer_fetch, resp_ok;
  logic [OFF_W:0]   sum;
  logic [OFF_W-1:0] span_len;
  logic [CLEN_W-1:0] clen;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_arch             <= '0;
      running_base         <= '0;
      running_version_low  <= '0;
      running_version_high <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_ARCH:         own_arch             <= pwdata[7:0];
        REG_BASE:         running_base         <= pwdata[7:0];
        REG_VERSION_LOW:  running_version_low  <= pwdata[7:0];
        REG_VERSION_HIGH: running_version_high <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_ARCH:         prdata = {24'd0, own_arch};
      REG_BASE:         prdata = {24'd0, running_base};
      REG_VERSION_LOW:  prdata = {24'd0, running_version_low};
      REG_VERSION_HIGH: prdata = {24'd0, running_version_high};
      default:          prdata = '0;
    endcase
  end

  // ---------------- per-item logic ----------------
  assign pkt      = pkt_t'(s_tdata);
  assign cmd      = cmd_t'(s_tuser);
  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  assign match       = (pkt.pkt_arch == own_arch) && (pkt.pkt_base == running_base);
  assign newer_run   = {pkt.pkt_version_high, pkt.pkt_version_low} >
                       {running_version_high, running_version_low};
  assign newer_fetch = {pkt.pkt_version_high, pkt.pkt_version_low} >
                       {fetch_version_high, fetch_version_low};
  assign resp_ok     = match && (fetch_mode != MODE_IDLE) &&
                       (pkt.pkt_version_low == fetch_version_low) &&
                       (pkt.pkt_version_high == fetch_version_high) &&
                       (pkt.pkt_offset == next_offset) &&
                       (pkt.pkt_offset < OFF_W'(BANK_SPAN));

  // full sum kept for the completion test
  assign sum      = {1'b0, pkt.pkt_offset} + (OFF_W+1)'(CHUNK_BYTES);
  assign span_len = (pkt.pkt_length > pkt.pkt_offset) ?
                    pkt.pkt_length - pkt.pkt_offset : '0;
  assign clen     = (span_len > OFF_W'(CHUNK_BYTES)) ? CLEN_W'(CHUNK_BYTES)
                                                     : span_len[CLEN_W-1:0];

  always_comb begin
    fetch_mode_next         = fetch_mode;
    retries_left_next       = retries_left;
    next_offset_next        = next_offset;
    fetch_version_low_next  = fetch_version_low;
    fetch_version_high_next = fetch_version_high;
    peer_mac_next           = peer_mac;
    bank_choice_next        = bank_choice;
    res                     = '0;

    unique case (cmd)
      CMD_ADVERT: begin
        if (match && newer_run && newer_fetch) begin
          fetch_version_low_next  = pkt.pkt_version_low;
          fetch_version_high_next = pkt.pkt_version_high;
          peer_mac_next           = {pkt.sender_mac_high, pkt.sender_mac_low};
          next_offset_next        = '0;
          bank_choice_next        = running_version_low[0];
          fetch_mode_next         = running_version_low[0] ? MODE_BANK1 : MODE_BANK0;
          retries_left_next       = RETRY_W'(RETRY_LIMIT);
          res.stop_timer          = 1'b1;
          res.send_request        = 1'b1;
          res.start_timer         = 1'b1;
          res.accepted            = 1'b1;
        end
      end
      CMD_RESPONSE: begin
        if (resp_ok) begin
          res.chunk_length = clen;
          res.stop_timer   = 1'b1;
          next_offset_next = sum[OFF_W-1:0];
          if (sum >= {1'b0, pkt.pkt_length}) begin
            res.transfer_done = 1'b1;
          end else begin
            retries_left_next = RETRY_W'(RETRY_LIMIT);
            res.send_request  = 1'b1;
            res.start_timer   = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (retries_left == '0) begin
          fetch_mode_next         = MODE_IDLE;
          fetch_version_low_next  = '0;
          fetch_version_high_next = '0;
        end else begin
          retries_left_next = retries_left - RETRY_W'(1);
          if (fetch_mode != MODE_IDLE) begin
            res.send_request = 1'b1;
            res.start_timer  = 1'b1;
          end
        end
      end
      CMD_NONE: ;
      default: ;
    endcase

    res.req_version_low  = fetch_version_low_next;
    res.req_version_high = fetch_version_high_next;
    res.req_offset       = next_offset_next;
    res.dest_mac_high    = peer_mac_next[63:32];
    res.dest_mac_low     = peer_mac_next[31:0];
    res.target_bank      = bank_choice_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_mode         <= MODE_IDLE;
      retries_left       <= '0;
      next_offset        <= '0;
      fetch_version_low  <= '0;
      fetch_version_high <= '0;
      peer_mac           <= '0;
      bank_choice        <= 1'b0;
    end else if (in_fire) begin
      fetch_mode         <= fetch_mode_next;
      retries_left       <= retries_left_next;
      next_offset        <= next_offset_next;
      fetch_version_low  <= fetch_version_low_next;
      fetch_version_high <= fetch_version_high_next;
      peer_mac           <= peer_mac_next;
      bank_choice        <= bank_choice_next;
    end
  end

  // ---------------- output register and skid ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!m_tvalid || out_fire) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!m_tvalid || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_tdata = OUT_W'(out_q);

endmodule

@@ rtl/otaif_checker.sv @@
// ----------------------------------------------------------------------------
// otaif_checker
// Port-level checks for the OTA image fetch receiver.
// ----------------------------------------------------------------------------
module otaif_checker
  import otaif_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  result_t r;
  assign r = result_t'(m_tdata);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a result is valid in the cycle after every word taken
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("word taken without a result");

  // a new fetch starts at offset zero and sends its first request
  a_accept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.accepted |->
      r.send_request && r.stop_timer && r.req_offset == '0 && r.chunk_length == '0)
    else $error("bad new-fetch result");

  // completion stops the timer without sending
  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.transfer_done |-> r.stop_timer && !r.send_request && !r.accepted)
    else $error("bad completion result");

  // chunk length never exceeds one chunk, and appears only with a response
  a_clen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.chunk_length != '0 |->
      r.chunk_length <= CLEN_W'(CHUNK_BYTES) && r.stop_timer && !r.accepted)
    else $error("bad chunk length");

endmodule

bind ota_image_fetch_protocol otaif_checker u_otaif_checker (.*);
